>>> src/esa_pkg.sv
// Shared types and constants for the entity slot allocator.
package esa_pkg;

	localparam int MAX_SLOTS           = 256;
	localparam int NUM_COMPONENT_TYPES = 32;
	localparam int SLOT_W              = 8;
	localparam int CNT_W               = 9;
	localparam int MASK_W              = 32;
	localparam int CMD_W               = 3;
	localparam int COMP_W              = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE  = 3'd0,
		CMD_DESTROY = 3'd1,
		CMD_ADD     = 3'd2,
		CMD_REMOVE  = 3'd3,
		CMD_HAS     = 3'd4,
		CMD_QUERY   = 3'd5
	} cmd_t;

	typedef struct packed {
		logic              alive;
		logic [MASK_W-1:0] mask;
	} slot_entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_entry_t       data;
	} slot_wr_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [SLOT_W-1:0] data;
	} stack_op_t;

endpackage

>>> src/esa_req_if.sv
// Request channel interface: command, entity slot and component index.
interface esa_req_if;
	import esa_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SLOT_W-1:0] entity_id;
	logic [COMP_W-1:0] component_id;

	modport source (output valid, command, entity_id, component_id, input ready);
	modport sink (input valid, command, entity_id, component_id, output ready);
endinterface

>>> src/esa_rsp_if.sv
// Response channel interface: status, slot, component mask and counters.
interface esa_rsp_if;
	import esa_pkg::*;

	logic              valid;
	logic              ready;
	logic              ok;
	logic [SLOT_W-1:0] slot_out;
	logic [MASK_W-1:0] component_mask;
	logic [CNT_W-1:0]  live_count;
	logic [CNT_W-1:0]  used_count;

	modport source (output valid, ok, slot_out, component_mask, live_count, used_count,
		input ready);
	modport sink (input valid, ok, slot_out, component_mask, live_count, used_count,
		output ready);
endinterface

>>> src/entity_slot_allocator_with_masks_top.sv
// Top level of the entity slot allocator with per-slot component masks.
//
// The req channel carries one command request: create, destroy, add,
// remove or has component, or query, with the entity slot and component
// index it addresses. Every request yields exactly one response on the rsp
// channel with a status bit, the slot granted or echoed, the slot's
// component mask after the command, and the live and used slot counts.
// When a request is accepted, the slot table and the free stack are read
// into registers; in the execute stage the command is decided, both
// memories are written back and the response register is loaded once it is
// free or being drained. The synchronous memories are read through registers,
// so the block takes no new request while one waits in the execute stage.
// When the receiver stalls, the response register holds its contents and a
// request already read waits in the execute stage without touching memory,
// while no further request is taken. Reset clears the counters and the
// handshake state; the memories need no clearing because only slots below
// the high-water mark are ever trusted.
module entity_slot_allocator_with_masks_top (
	input  logic clk,
	input  logic arst_n,
	esa_req_if.sink   req,
	esa_rsp_if.source rsp
);
	import esa_pkg::*;

	// Execute stage registers.
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [SLOT_W-1:0] id_s1;
	logic [COMP_W-1:0] comp_s1;

	// Allocator state and response register.
	logic [CNT_W-1:0]  high_water_q;
	logic              rsp_valid_q;
	logic              ok_q;
	logic [SLOT_W-1:0] slot_q;
	logic [MASK_W-1:0] mask_q;
	logic [CNT_W-1:0]  live_q;
	logic [CNT_W-1:0]  used_q;

	logic              accept;
	logic              commit;
	slot_entry_t       entry;
	logic [SLOT_W-1:0] top_slot;
	logic [CNT_W-1:0]  free_top;
	slot_wr_t          wr_raw;
	slot_wr_t          wr;
	stack_op_t         op_raw;
	stack_op_t         op;

	logic              slot_valid;
	logic              comp_ok;
	logic [MASK_W-1:0] comp_bit;
	logic              has_bit;
	logic              ok_d;
	logic [SLOT_W-1:0] slot_d;
	logic [MASK_W-1:0] mask_d;
	logic [CNT_W-1:0]  high_water_d;
	logic [CNT_W-1:0]  free_top_d;

	// Only one request is in the execute stage at a time, so a memory write
	// never meets a read of the same cycle.
	assign req.ready = !valid_s1;
	assign accept    = req.valid && req.ready;
	assign commit    = valid_s1 && (!rsp_valid_q || rsp.ready);

	esa_slot_table u_slot_table (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (req.entity_id),
		.rd_data (entry),
		.wr      (wr)
	);

	esa_free_stack u_free_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.op       (op),
		.top_slot (top_slot),
		.free_top (free_top)
	);

	// A slot is valid when it lies below the high-water mark and is alive.
	assign slot_valid = entry.alive && ({1'b0, id_s1} < high_water_q);
	assign comp_ok    = (32'(comp_s1) < 32'(NUM_COMPONENT_TYPES));
	assign comp_bit   = comp_ok ? (MASK_W'(1) << comp_s1) : '0;
	assign has_bit    = |(entry.mask & comp_bit);

	always_comb begin
		ok_d         = 1'b0;
		slot_d       = id_s1;
		mask_d       = '0;
		high_water_d = high_water_q;
		wr_raw       = '0;
		op_raw       = '0;
		unique case (cmd_s1)
			CMD_CREATE: begin
				// Recycled slots come first; fresh ones follow the mark.
				slot_d = '0;
				if (free_top != '0) begin
					op_raw.pop = 1'b1;
					slot_d     = top_slot;
					ok_d       = 1'b1;
				end else if (high_water_q < CNT_W'(MAX_SLOTS)) begin
					slot_d       = high_water_q[SLOT_W-1:0];
					high_water_d = high_water_q + CNT_W'(1);
					ok_d         = 1'b1;
				end
				if (ok_d) begin
					wr_raw.en         = 1'b1;
					wr_raw.addr       = slot_d;
					wr_raw.data.alive = 1'b1;
					wr_raw.data.mask  = '0;
				end
			end
			CMD_DESTROY: begin
				if (slot_valid) begin
					wr_raw.en   = 1'b1;
					wr_raw.addr = id_s1;
					if (free_top < CNT_W'(MAX_SLOTS)) begin
						op_raw.push = 1'b1;
						op_raw.data = id_s1;
					end
					ok_d = 1'b1;
				end
			end
			CMD_ADD: begin
				if (slot_valid) begin
					mask_d = entry.mask;
					if (comp_ok && !has_bit) begin
						mask_d            = entry.mask | comp_bit;
						wr_raw.en         = 1'b1;
						wr_raw.addr       = id_s1;
						wr_raw.data.alive = 1'b1;
						wr_raw.data.mask  = entry.mask | comp_bit;
						ok_d              = 1'b1;
					end
				end
			end
			CMD_REMOVE: begin
				if (slot_valid) begin
					mask_d = entry.mask;
					if (comp_ok && has_bit) begin
						mask_d            = entry.mask & ~comp_bit;
						wr_raw.en         = 1'b1;
						wr_raw.addr       = id_s1;
						wr_raw.data.alive = 1'b1;
						wr_raw.data.mask  = entry.mask & ~comp_bit;
						ok_d              = 1'b1;
					end
				end
			end
			CMD_HAS: begin
				if (slot_valid) begin
					mask_d = entry.mask;
					ok_d   = comp_ok && has_bit;
				end
			end
			CMD_QUERY: begin
				if (slot_valid) begin
					mask_d = entry.mask;
					ok_d   = 1'b1;
				end
			end
			default: begin
				// Unknown commands are refused and change nothing.
				ok_d = 1'b0;
			end
		endcase
	end

	// Memory updates take effect only when the response can be loaded.
	always_comb begin
		wr    = wr_raw;
		op    = op_raw;
		wr.en = wr_raw.en && commit;
		op.push = op_raw.push && commit;
		op.pop  = op_raw.pop && commit;
	end

	assign free_top_d = free_top + CNT_W'(op_raw.push) - CNT_W'(op_raw.pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			high_water_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q  <= 1'b1;
				high_water_q <= high_water_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= req.command;
			id_s1   <= req.entity_id;
			comp_s1 <= req.component_id;
		end
		if (commit) begin
			ok_q   <= ok_d;
			slot_q <= slot_d;
			mask_q <= mask_d;
			live_q <= high_water_d - free_top_d;
			used_q <= high_water_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.ok             = ok_q;
	assign rsp.slot_out       = slot_q;
	assign rsp.component_mask = mask_q;
	assign rsp.live_count     = live_q;
	assign rsp.used_count     = used_q;
endmodule

>>> src/esa_slot_table.sv
// Slot table memory holding the alive bit and component mask of every slot.
module esa_slot_table (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [esa_pkg::SLOT_W-1:0] rd_addr,
	output esa_pkg::slot_entry_t    rd_data,
	input  esa_pkg::slot_wr_t       wr
);
	import esa_pkg::*;

	slot_entry_t mem [MAX_SLOTS];
	slot_entry_t rd_data_q;

	// Entries at or above the high-water mark are never trusted, so the
	// array needs no clearing after reset.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> src/esa_free_stack.sv
// Free slot stack: memory of recycled slots and its top pointer.
module esa_free_stack (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  esa_pkg::stack_op_t         op,
	output logic [esa_pkg::SLOT_W-1:0] top_slot,
	output logic [esa_pkg::CNT_W-1:0]  free_top
);
	import esa_pkg::*;

	logic [SLOT_W-1:0] mem [MAX_SLOTS];
	logic [SLOT_W-1:0] top_q;
	logic [CNT_W-1:0]  free_top_q;

	// The entry read below the pointer is only used when the stack is not empty.
	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[free_top_q[SLOT_W-1:0]] <= op.data;
		end
		if (rd_en) begin
			top_q <= mem[SLOT_W'(free_top_q - CNT_W'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q <= '0;
		end else if (op.push) begin
			free_top_q <= free_top_q + CNT_W'(1);
		end else if (op.pop) begin
			free_top_q <= free_top_q - CNT_W'(1);
		end
	end

	assign top_slot = top_q;
	assign free_top = free_top_q;
endmodule
